// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the lucas_kanade_patch_flow RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never be true at a clock edge outside reset.
`define LKPF_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

// Whenever trig holds, prop must hold in the same cycle.
`define LKPF_IMPLY(lbl, trig, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (prop)) \
        else $error(msg);

`endif

// ===== hdl/lkpf_pkg.sv =====
// Types and constants shared by the Lucas-Kanade patch flow modules.
`timescale 1ns / 1ps

package lkpf_pkg;

    localparam int PIX_W   = 8;
    localparam int GRAD_W  = PIX_W + 1;         // signed pixel difference
    localparam int PROD_W  = 2 * GRAD_W;        // gradient product
    localparam int SQ_W    = 24;                // unsigned square sums
    localparam int XS_W    = 25;                // signed cross sums
    localparam int MUL_W   = 2 * XS_W;          // solve multiplier product
    localparam int ACC_W   = MUL_W + 1;         // determinant and numerators
    localparam int FRAC_SH = 10;                // 512 * 2 for round-half-up
    localparam int QUO_W   = 17;                // quotient bits before clamp
    localparam int DIV_W   = ACC_W + FRAC_SH + QUO_W + 2;
    localparam int QCNT_W  = $clog2(QUO_W);
    localparam int OUT_W   = 16;

    localparam logic [QUO_W-1:0] Q_POS_LIM = QUO_W'(32767);
    localparam logic [QUO_W-1:0] Q_NEG_LIM = QUO_W'(32768);
    localparam logic [OUT_W-1:0] SAT_POS   = 16'h7FFF;
    localparam logic [OUT_W-1:0] SAT_NEG   = 16'h8000;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_QW = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [PIX_W-1:0] prev_left;
        logic [PIX_W-1:0] prev_right;
        logic [PIX_W-1:0] prev_above;
        logic [PIX_W-1:0] prev_below;
        logic [PIX_W-1:0] prev_center;
        logic [PIX_W-1:0] curr_pixel;
        logic             last;
    } t_in_word;

    typedef struct packed {
        logic signed [OUT_W-1:0] delta_x;
        logic signed [OUT_W-1:0] delta_y;
        logic                    status;
    } t_out_word;

    typedef struct packed {
        logic [SQ_W-1:0]        sxx;
        logic [SQ_W-1:0]        syy;
        logic signed [XS_W-1:0] sxy;
        logic signed [XS_W-1:0] sxt;
        logic signed [XS_W-1:0] syt;
    } t_sums;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_DSET,
        ST_DIV,
        ST_DFIN,
        ST_OUT
    } t_solve_state;

    // Product schedule of the shared solve multiplier.
    typedef enum logic [2:0] {
        MS_XX_YY,
        MS_XY_XY,
        MS_XY_YT,
        MS_YY_XT,
        MS_XY_XT,
        MS_XX_YT,
        MS_DRAIN
    } t_mul_step;

endpackage

// ===== hdl/lkpf_front.sv =====
// Front end: gradient products and per-patch accumulation, one word per cycle unless the queue is full.
`timescale 1ns / 1ps

module lkpf_front import lkpf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_word i_data,
    input  t_q_stat  i_q_stat,
    output logic     o_push,
    output t_sums    o_sums
);

    logic [SQ_W-1:0]        r_sxx, r_syy;
    logic signed [XS_W-1:0] r_sxy, r_sxt, r_syt;
    t_sums                  n_sums;

    logic signed [GRAD_W-1:0] gx, gy, gt;
    logic signed [PROD_W-1:0] pxx, pyy, pxy, pxt, pyt;
    logic                     accept;

    assign gx = $signed({1'b0, i_data.prev_right}) - $signed({1'b0, i_data.prev_left});
    assign gy = $signed({1'b0, i_data.prev_below}) - $signed({1'b0, i_data.prev_above});
    assign gt = $signed({1'b0, i_data.curr_pixel}) - $signed({1'b0, i_data.prev_center});

    assign pxx = gx * gx;
    assign pyy = gy * gy;
    assign pxy = gx * gy;
    assign pxt = gx * gt;
    assign pyt = gy * gt;

    // Sums wrap at their widths.
    always_comb begin
        n_sums.sxx = r_sxx + SQ_W'(pxx);
        n_sums.syy = r_syy + SQ_W'(pyy);
        n_sums.sxy = r_sxy + XS_W'(pxy);
        n_sums.sxt = r_sxt + XS_W'(pxt);
        n_sums.syt = r_syt + XS_W'(pyt);
    end

    assign o_stall = i_q_stat.full;
    assign accept  = i_valid && !i_q_stat.full;
    assign o_push  = accept && i_data.last;
    assign o_sums  = n_sums;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sxx <= '0;
            r_syy <= '0;
            r_sxy <= '0;
            r_sxt <= '0;
            r_syt <= '0;
        end else if (accept) begin
            if (i_data.last) begin
                r_sxx <= '0;
                r_syy <= '0;
                r_sxy <= '0;
                r_sxt <= '0;
                r_syt <= '0;
            end else begin
                r_sxx <= n_sums.sxx;
                r_syy <= n_sums.syy;
                r_sxy <= n_sums.sxy;
                r_sxt <= n_sums.sxt;
                r_syt <= n_sums.syt;
            end
        end
    end

endmodule

// ===== hdl/lkpf_queue.sv =====
// Short queue of finished patch sums between front end and solver.
`timescale 1ns / 1ps

module lkpf_queue import lkpf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_sums   i_wdata,
    input  logic    i_pop,
    output t_sums   o_rdata,
    output t_q_stat o_stat
);

    t_sums               r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wp, r_rp;
    logic [QCNT_QW-1:0]  r_cnt;

    assign o_stat.full  = (r_cnt == QCNT_QW'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_rdata      = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_QW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_QW'(1);
            end
        end
    end

endmodule

// ===== hdl/lkpf_solve.sv =====
// Back end: 2x2 solve with a shared multiplier and a radix-2 divider.
`timescale 1ns / 1ps

module lkpf_solve import lkpf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_stat   i_q_stat,
    output logic      o_pop,
    input  t_sums     i_sums,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_data
);

    t_solve_state r_state, n_state;
    t_mul_step    r_step, r_pstep;
    logic         r_sel;
    logic [QCNT_W-1:0] r_cnt;
    logic         r_ovalid;

    logic [SQ_W-1:0]         r_sxx, r_syy;
    logic signed [XS_W-1:0]  r_sxy, r_sxt, r_syt;
    logic signed [MUL_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_det, r_nu, r_nv;
    logic                    r_neg, r_ovf;
    logic [DIV_W-1:0]        r_rem, r_dvs;
    logic [QUO_W-1:0]        r_q;
    logic signed [OUT_W-1:0] r_dx, r_dy;
    logic                    r_status;
    t_out_word               r_odata;

    logic signed [XS_W-1:0]  mul_a, mul_b;
    logic signed [ACC_W-1:0] num_sel;
    logic [ACC_W-1:0]        mag_n, mag_d;
    logic [DIV_W-1:0]        div_a, div_b;
    logic                    div_ovf, div_ge;
    logic [OUT_W-1:0]        sat_val;
    logic                    pop, load_out;

    // Operand select for the multiplier schedule.
    always_comb begin
        unique case (r_step)
            MS_XX_YY: begin mul_a = $signed({1'b0, r_sxx}); mul_b = $signed({1'b0, r_syy}); end
            MS_XY_XY: begin mul_a = r_sxy; mul_b = r_sxy; end
            MS_XY_YT: begin mul_a = r_sxy; mul_b = r_syt; end
            MS_YY_XT: begin mul_a = $signed({1'b0, r_syy}); mul_b = r_sxt; end
            MS_XY_XT: begin mul_a = r_sxy; mul_b = r_sxt; end
            MS_XX_YT: begin mul_a = $signed({1'b0, r_sxx}); mul_b = r_syt; end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // Divider setup: q = (|N|*1024 + |D|) / (2|D|), 17 quotient bits.
    always_comb begin
        num_sel = r_sel ? r_nv : r_nu;
        mag_n   = num_sel[ACC_W-1] ? ACC_W'(-num_sel) : ACC_W'(num_sel);
        mag_d   = r_det[ACC_W-1] ? ACC_W'(-r_det) : ACC_W'(r_det);
        div_a   = (DIV_W'(mag_n) << FRAC_SH) + DIV_W'(mag_d);
        div_b   = DIV_W'(mag_d) << 1;
        div_ovf = (div_a >= (div_b << QUO_W));
        div_ge  = (r_rem >= r_dvs);
    end

    // Round-to-nearest quotient clamped to Q6.9.
    always_comb begin
        if (r_neg) begin
            sat_val = (r_ovf || r_q > Q_NEG_LIM) ? SAT_NEG : OUT_W'(~r_q + QUO_W'(1));
        end else begin
            sat_val = (r_ovf || r_q > Q_POS_LIM) ? SAT_POS : OUT_W'(r_q);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (!i_q_stat.empty) n_state = ST_MUL;
            ST_MUL:   if (r_step == MS_DRAIN) n_state = ST_CHECK;
            ST_CHECK: n_state = (r_det == '0) ? ST_OUT : ST_DSET;
            ST_DSET:  n_state = ST_DIV;
            ST_DIV:   if (r_cnt == '0) n_state = ST_DFIN;
            ST_DFIN:  n_state = r_sel ? ST_OUT : ST_DSET;
            ST_OUT:   if (!r_ovalid || !i_stall) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        pop      = (r_state == ST_IDLE) && !i_q_stat.empty;
        load_out = (r_state == ST_OUT) && (!r_ovalid || !i_stall);
    end

    assign o_pop   = pop;
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= MS_XX_YY;
            r_sel    <= 1'b0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (pop) begin
                r_step <= MS_XX_YY;
            end else if (r_state == ST_MUL && r_step != MS_DRAIN) begin
                r_step <= t_mul_step'(r_step + 3'd1);
            end
            if (r_state == ST_CHECK) begin
                r_sel <= 1'b0;
            end else if (r_state == ST_DFIN) begin
                r_sel <= 1'b1;
            end
            if (r_state == ST_DSET) begin
                r_cnt <= QCNT_W'(QUO_W - 1);
            end else if (r_state == ST_DIV) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_sxx <= i_sums.sxx;
            r_syy <= i_sums.syy;
            r_sxy <= i_sums.sxy;
            r_sxt <= i_sums.sxt;
            r_syt <= i_sums.syt;
        end
        if (r_state == ST_MUL) begin
            r_prod  <= mul_a * mul_b;
            r_pstep <= r_step;
            if (r_step != MS_XX_YY) begin
                unique case (r_pstep)
                    MS_XX_YY: r_det <= ACC_W'(r_prod);
                    MS_XY_XY: r_det <= r_det - ACC_W'(r_prod);
                    MS_XY_YT: r_nu  <= ACC_W'(r_prod);
                    MS_YY_XT: r_nu  <= r_nu - ACC_W'(r_prod);
                    MS_XY_XT: r_nv  <= ACC_W'(r_prod);
                    MS_XX_YT: r_nv  <= r_nv - ACC_W'(r_prod);
                    default:  ;
                endcase
            end
        end
        if (r_state == ST_CHECK) begin
            r_dx     <= '0;
            r_dy     <= '0;
            r_status <= (r_det == '0);
        end
        if (r_state == ST_DSET) begin
            r_rem <= div_a;
            r_dvs <= div_b << (QUO_W - 1);
            r_ovf <= div_ovf;
            r_neg <= num_sel[ACC_W-1] ^ r_det[ACC_W-1];
            r_q   <= '0;
        end
        if (r_state == ST_DIV) begin
            r_rem <= div_ge ? r_rem - r_dvs : r_rem;
            r_dvs <= r_dvs >> 1;
            r_q   <= {r_q[QUO_W-2:0], div_ge};
        end
        if (r_state == ST_DFIN) begin
            if (r_sel) begin
                r_dy <= $signed(sat_val);
            end else begin
                r_dx <= $signed(sat_val);
            end
        end
        if (load_out) begin
            r_odata.delta_x <= r_dx;
            r_odata.delta_y <= r_dy;
            r_odata.status  <= r_status;
        end
    end

endmodule

// ===== hdl/lucas_kanade_patch_flow.sv =====
// A patch result is registered after the multiplier steps and both divisions (none if det is 0).
// The front end takes one word per cycle unless the queue is full; the solver finishes
//   one patch (7 shared-multiplier steps, two 17-step radix-2 divisions) before it pops the next.
// A two-entry queue of patch sums lets the front end run while the solver works.
// Reset: i_rst_n synchronous active low; clears sums, queue and solver control.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module lucas_kanade_patch_flow import lkpf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // input word channel
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_data,
    // result word channel
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_data
);

    // Front end -> queue
    logic    push;
    t_sums   push_sums;
    // Queue -> solver
    logic    pop;
    t_sums   head_sums;
    t_q_stat q_stat;
    // Zero-determinant word check
    logic    zero_det_out;
    logic    deltas_zero;

    // Gradients and products accumulate at full word rate while the queue has room; the last word of a
    // patch hands its completed sums to the queue and restarts the sums.
    lkpf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_stall  (o_in_stall),
        .i_data   (i_in_data),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_sums   (push_sums)
    );

    // Front end stalls only when both queue slots hold unsolved patches.
    lkpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_sums),
        .i_pop   (pop),
        .o_rdata (head_sums),
        .o_stat  (q_stat)
    );

    // Determinant and numerators, then rounded saturating Q6.9 division;
    // result held in an output register until the sink takes it.
    lkpf_solve u_solve (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .i_sums   (head_sums),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_data   (o_out_data)
    );

    assign zero_det_out = o_out_valid && o_out_data.status;
    assign deltas_zero  = (o_out_data.delta_x == '0) && (o_out_data.delta_y == '0);

    `LKPF_NEVER(a_push_full, push && q_stat.full, "patch sums pushed into a full queue")
    `LKPF_NEVER(a_pop_empty, pop && q_stat.empty, "solver popped an empty queue")
    `LKPF_IMPLY(a_zero_det, zero_det_out, deltas_zero, "zero determinant word with nonzero deltas")

endmodule
